// File: design/i2crw_pkg.sv
// Shared types, codes and the pin decode for the I2C register write master.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package i2crw_pkg;

  // Default width of the per-phase tick counter
  localparam int unsigned TICK_CNT_W_DEF = 16;

  // Configuration register indexes and reset values
  localparam logic [3:0]  CFG_DEV_ADDR    = 4'd0;
  localparam logic [3:0]  CFG_PHASE_TICKS = 4'd1;
  localparam logic [7:0]  DEV_ADDR_RST    = 8'hE0;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd300;

  // Input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Phase bookkeeping: a group is three phases (low / high / low of SCL
  // for data and ack groups); group 0 is start, the last is stop.
  localparam logic [4:0] GRP_START = 5'd0;
  localparam logic [4:0] GRP_STOP  = 5'd28;
  localparam logic [3:0] SLOT_ACK  = 4'd8;
  localparam logic [1:0] SUB_HIGH  = 2'd1;
  localparam logic [1:0] SUB_LAST  = 2'd2;

  typedef struct packed {
    logic [7:0] data_value;
    logic [7:0] register_address;
    logic       command;
  } item_t;

  typedef struct packed {
    logic drv;
    logic sda;
    logic scl;
  } pins_t;

  typedef struct packed {
    logic  done_res;
    logic  busy_res;
    pins_t pins;
  } result_t;

  localparam pins_t PINS_IDLE = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};

  // Pin levels at the beginning of a phase
  function automatic pins_t phase_pins(input logic [4:0] grp, input logic [1:0] sub,
                                       input logic [3:0] slot, input logic bit_val,
                                       input logic sda_hold);
    pins_t p;
    p = PINS_IDLE;
    if (grp == GRP_START) begin
      p.sda = (sub == 2'd0);
      p.scl = (sub != SUB_LAST);
    end else if (grp == GRP_STOP) begin
      p.sda = (sub == SUB_LAST);
      p.scl = (sub != 2'd0);
    end else if (slot == SLOT_ACK) begin
      // release SDA, level keeps the last bit sent
      p.drv = 1'b0;
      p.sda = sda_hold;
      p.scl = (sub == SUB_HIGH);
    end else begin
      p.drv = 1'b1;
      p.sda = bit_val;
      p.scl = (sub == SUB_HIGH);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: design/i2crw_in_stage.sv
// Input register stage: holds one accepted word until the sequencer takes it.
// Depends on i2crw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_in_stage import i2crw_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  output logic       valid_o,
  input  wire        pop_i,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || pop_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (pop_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: design/i2crw_seq.sv
// Phase sequencer: tick counter, phase position, byte shifter and pin state.
// Depends on i2crw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_seq import i2crw_pkg::*; #(
  parameter int unsigned TICK_CNT_W = TICK_CNT_W_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         fire_i,
  input  wire item_t  item_i,
  input  wire  [7:0]  dev_addr_i,
  input  wire  [15:0] phase_ticks_i,
  output result_t     result_o
);

  logic                  busy_q, busy_d;
  logic [4:0]            grp_q, grp_d;
  logic [1:0]            sub_q, sub_d;
  logic [3:0]            slot_q, slot_d;
  logic [23:0]           sh_q, sh_d;
  logic [TICK_CNT_W-1:0] cnt_q, cnt_d, cnt_inc, lim;
  pins_t                 pins_q, pins_d;
  logic                  done;
  logic [15:0]           lim_raw;

  // zero phase length acts as one tick
  assign lim_raw = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;

  if (TICK_CNT_W < 16) begin : g_lim_sat
    localparam logic [15:0] CntMax = 16'((64'd1 << TICK_CNT_W) - 64'd1);
    assign lim = (lim_raw > CntMax) ? CntMax[TICK_CNT_W-1:0] : lim_raw[TICK_CNT_W-1:0];
  end else begin : g_lim_ext
    assign lim = TICK_CNT_W'(lim_raw);
  end

  assign cnt_inc = cnt_q + TICK_CNT_W'(1);

  always_comb begin
    busy_d = busy_q;
    grp_d  = grp_q;
    sub_d  = sub_q;
    slot_d = slot_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    pins_d = pins_q;
    done   = 1'b0;
    if (fire_i) begin
      if (item_i.command == CMD_WRITE) begin
        if (!busy_q) begin
          sh_d   = {dev_addr_i, item_i.register_address, item_i.data_value};
          busy_d = 1'b1;
          grp_d  = GRP_START;
          sub_d  = 2'd0;
          slot_d = 4'd0;
          cnt_d  = '0;
          pins_d = PINS_IDLE;
        end
      end else if (busy_q) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= lim) begin
          cnt_d = '0;
          if (grp_q == GRP_STOP && sub_q == SUB_LAST) begin
            busy_d = 1'b0;
            grp_d  = GRP_START;
            sub_d  = 2'd0;
            done   = 1'b1;
            pins_d = PINS_IDLE;
          end else begin
            if (sub_q != SUB_LAST) begin
              sub_d = sub_q + 2'd1;
            end else begin
              sub_d = 2'd0;
              grp_d = grp_q + 5'd1;
              if (grp_q == GRP_START || slot_q == SLOT_ACK) begin
                slot_d = 4'd0;
              end else begin
                // data bit finished: bring the next one to the top
                slot_d = slot_q + 4'd1;
                sh_d   = {sh_q[22:0], 1'b0};
              end
            end
            pins_d = phase_pins(grp_d, sub_d, slot_d, sh_d[23], pins_q.sda);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= GRP_START;
      sub_q  <= 2'd0;
      slot_q <= 4'd0;
      sh_q   <= '0;
      cnt_q  <= '0;
      pins_q <= PINS_IDLE;
    end else begin
      busy_q <= busy_d;
      grp_q  <= grp_d;
      sub_q  <= sub_d;
      slot_q <= slot_d;
      sh_q   <= sh_d;
      cnt_q  <= cnt_d;
      pins_q <= pins_d;
    end
  end

  assign result_o = '{done_res: done, busy_res: busy_d, pins: pins_d};

  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q) else $error("done without an active sequence");
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd3) else $error("phase sub-step out of range");
  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_q <= GRP_STOP) else $error("phase group out of range");
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pins_q == PINS_IDLE && grp_q == GRP_START))
    else $error("pins not released while idle");

endmodule

`default_nettype wire

// File: design/i2crw_out_stage.sv
// Result register: holds one result word until the sink takes it.
// Depends on i2crw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2crw_out_stage import i2crw_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          load_i,
  output logic         ready_o,
  input  wire result_t result_i,
  output logic         valid_o,
  input  wire          ready_i,
  output result_t      result_o
);

  logic    valid_q;
  result_t result_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// File: design/i2c_register_write_master.sv
// Top level of the I2C register write master: streams, config registers.
// Depends on i2crw_pkg, i2crw_in_stage, i2crw_seq and i2crw_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Bit-banged I2C write master driven by a stream of tick words. A word with
// command 1 while idle latches {device address byte, register, data} and
// starts one write: start condition, three bytes MSB first each followed by
// one acknowledge clock pulse with SDA released (not sampled), then stop:
// 87 pin phases, each lasting phase_ticks tick words (command 0). A request
// while busy is dropped and counts as no tick. Every input word yields
// exactly one result word carrying the pin levels after that word, busy and
// a one-word done pulse at the end of the stop condition. Throughput is one
// word per clock unless the result stream stalls; a word passes the input
// register, then the result register written by the sequencer update.
// Configuration goes through the cfg port, always ready; write it while idle.

module i2c_register_write_master import i2crw_pkg::*; #(
  parameter int unsigned TICK_COUNTER_WIDTH = TICK_CNT_W_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [7:0] register_address, [15:8] data_value
  input  wire         s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] sda_drive,
                                      // [3] busy_res, [4] done_res, [7:5] zero
  // configuration writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  logic [7:0]  dev_addr_q;
  logic [15:0] phase_ticks_q;

  item_t   in_item, stage_item;
  logic    stage_valid, out_ready, fire;
  result_t seq_result, out_result;

  // Config registers: always accept, drop writes to unknown indexes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[7:0];
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{data_value: s_axis_tdata[15:8],
                     register_address: s_axis_tdata[7:0],
                     command: s_axis_tuser};

  i2crw_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .pop_i   (fire),
    .item_o  (stage_item)
  );

  // Advance the sequencer whenever a held word meets room in the result register
  assign fire = stage_valid && out_ready;

  i2crw_seq #(
    .TICK_CNT_W (TICK_COUNTER_WIDTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (stage_item),
    .dev_addr_i    (dev_addr_q),
    .phase_ticks_i (phase_ticks_q),
    .result_o      (seq_result)
  );

  i2crw_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .ready_o  (out_ready),
    .result_i (seq_result),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {3'b000, out_result};

endmodule

`default_nettype wire
